[design/asc_pkg.sv]
// ----------------------------------------------------------------------------
// Arctangent soft clipper package
// Shared widths, beat types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package asc_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int CFG_W             = 24;
	localparam int CFG_IDX_W         = 1;
	localparam int XY_W              = 42;
	localparam int Z_W               = 32;
	localparam int TABLE_LEN         = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'b1;

	localparam logic [CFG_W-1:0] DRIVE_GAIN_RST   = 24'd16;
	localparam logic [CFG_W-1:0] OUTPUT_SCALE_RST = 24'd16384000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       last_in;
	} asc_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       last_out;
	} asc_out_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} asc_vec_t;

	function automatic logic signed [Z_W-1:0] atan_tab(input int idx);
		logic signed [Z_W-1:0] t;
		case (idx)
			0:       t = 32'sd843314857;
			1:       t = 32'sd497837829;
			2:       t = 32'sd263043837;
			3:       t = 32'sd133525159;
			4:       t = 32'sd67021687;
			5:       t = 32'sd33543516;
			6:       t = 32'sd16775851;
			7:       t = 32'sd8388437;
			8:       t = 32'sd4194283;
			9:       t = 32'sd2097149;
			10:      t = 32'sd1048576;
			11:      t = 32'sd524288;
			12:      t = 32'sd262144;
			13:      t = 32'sd131072;
			14:      t = 32'sd65536;
			15:      t = 32'sd32768;
			16:      t = 32'sd16384;
			17:      t = 32'sd8192;
			18:      t = 32'sd4096;
			19:      t = 32'sd2048;
			20:      t = 32'sd1024;
			21:      t = 32'sd512;
			22:      t = 32'sd256;
			23:      t = 32'sd128;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

[design/asc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation with a fixed shift, registered towards the
// next cell of the chain.
// ----------------------------------------------------------------------------
module asc_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  asc_pkg::asc_vec_t vec,
	output asc_pkg::asc_vec_t vec_q
);

	localparam logic signed [asc_pkg::Z_W-1:0] ANGLE = asc_pkg::atan_tab(STAGE);

	logic signed [asc_pkg::XY_W-1:0] dx;
	logic signed [asc_pkg::XY_W-1:0] dy;

	assign dx = vec.y >>> STAGE;
	assign dy = vec.x >>> STAGE;

	always_ff @(posedge clk) begin
		if (!vec.y[asc_pkg::XY_W-1]) begin
			vec_q.x <= vec.x + dx;
			vec_q.y <= vec.y - dy;
			vec_q.z <= vec.z + ANGLE;
		end else begin
			vec_q.x <= vec.x - dx;
			vec_q.y <= vec.y + dy;
			vec_q.z <= vec.z - ANGLE;
		end
	end

endmodule

[design/asc_out_stage.sv]
// ----------------------------------------------------------------------------
// Output scaling stage
// Multiplies the angle by the output scale, rounds and saturates to Q1.15.
// ----------------------------------------------------------------------------
module asc_out_stage (
	input  logic                                clk,
	input  logic signed [asc_pkg::Z_W-1:0]      angle,
	input  logic        [asc_pkg::CFG_W-1:0]    scale,
	output logic signed [asc_pkg::SAMPLE_W-1:0] sample_q
);

	localparam int PROD_W = asc_pkg::Z_W + asc_pkg::CFG_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = {{(PROD_W-29){1'b0}}, 1'b1, 28'd0};
	localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-15){1'b0}}, {15{1'b1}}};
	localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-15){1'b1}}, {15{1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rounded;

	assign rounded = (prod_s1 + ROUND_BIAS) >>> 29;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(angle * $signed({1'b0, scale}));
		if (rounded > SAT_HI) begin
			sample_q <= SAT_HI[asc_pkg::SAMPLE_W-1:0];
		end else if (rounded < SAT_LO) begin
			sample_q <= SAT_LO[asc_pkg::SAMPLE_W-1:0];
		end else begin
			sample_q <= rounded[asc_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

[design/atan_soft_clip_distortion_core.sv]
// ----------------------------------------------------------------------------
// Arctangent soft clipper core
// Stereo atan waveshaper: gain, CORDIC arctangent chain, scale and saturate.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Handshake
//  input     start, busy, samples            beat taken when start and !busy
//  result    done, result                    beat valid for one cycle on done
//  config    cfg_we, cfg_index, cfg_wdata    written when cfg_we is high
//
//  One stereo beat is accepted every cycle; busy is always low.
//  Pipeline registers, in order: input gain, each CORDIC cell of the
//  chain, then output multiply and rounding.
//  Reset empties the pipeline and restores both registers to defaults.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module atan_soft_clip_distortion_core #(
	parameter int CORDIC_STAGES = asc_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  asc_pkg::asc_in_t                  samples,
	output logic                              done,
	output asc_pkg::asc_out_t                 result,
	input  logic                              cfg_we,
	input  logic [asc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asc_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int LATENCY = CORDIC_STAGES + 3;

	logic [asc_pkg::CFG_W-1:0] drive_gain_q;
	logic [asc_pkg::CFG_W-1:0] output_scale_q;
	logic [LATENCY-1:0]        valid_q;
	logic [LATENCY-1:0]        last_q;
	logic                      accept;

	logic signed [asc_pkg::SAMPLE_W+asc_pkg::CFG_W:0] left_prod;
	logic signed [asc_pkg::SAMPLE_W+asc_pkg::CFG_W:0] right_prod;

	logic signed [asc_pkg::SAMPLE_W-1:0] left_res;
	logic signed [asc_pkg::SAMPLE_W-1:0] right_res;

	asc_pkg::asc_vec_t vec_l_s0;
	asc_pkg::asc_vec_t vec_r_s0;

	asc_pkg::asc_vec_t vec_l [0:CORDIC_STAGES];
	asc_pkg::asc_vec_t vec_r [0:CORDIC_STAGES];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_gain_q   <= asc_pkg::DRIVE_GAIN_RST;
			output_scale_q <= asc_pkg::OUTPUT_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				asc_pkg::CFG_DRIVE_GAIN:   drive_gain_q   <= cfg_wdata;
				asc_pkg::CFG_OUTPUT_SCALE: output_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q  <= '0;
		end else begin
			valid_q <= {valid_q[LATENCY-2:0], accept};
			last_q  <= {last_q[LATENCY-2:0], samples.last_in};
		end
	end

	assign left_prod  = samples.left_in * $signed({1'b0, drive_gain_q});
	assign right_prod = samples.right_in * $signed({1'b0, drive_gain_q});

	always_ff @(posedge clk) begin
		vec_l_s0.x <= asc_pkg::XY_W'(64'sd536870912);
		vec_l_s0.y <= asc_pkg::XY_W'(left_prod);
		vec_l_s0.z <= '0;
		vec_r_s0.x <= asc_pkg::XY_W'(64'sd536870912);
		vec_r_s0.y <= asc_pkg::XY_W'(right_prod);
		vec_r_s0.z <= '0;
	end

	assign vec_l[0] = vec_l_s0;
	assign vec_r[0] = vec_r_s0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_chain
		asc_cordic_cell #(.STAGE(i)) u_cell_l (
			.clk   (clk),
			.vec   (vec_l[i]),
			.vec_q (vec_l[i+1])
		);
		asc_cordic_cell #(.STAGE(i)) u_cell_r (
			.clk   (clk),
			.vec   (vec_r[i]),
			.vec_q (vec_r[i+1])
		);
	end

	asc_out_stage u_out_l (
		.clk      (clk),
		.angle    (vec_l[CORDIC_STAGES].z),
		.scale    (output_scale_q),
		.sample_q (left_res)
	);

	asc_out_stage u_out_r (
		.clk      (clk),
		.angle    (vec_r[CORDIC_STAGES].z),
		.scale    (output_scale_q),
		.sample_q (right_res)
	);

	assign done   = valid_q[LATENCY-1];
	assign result = '{left_out: left_res, right_out: right_res, last_out: last_q[LATENCY-1]};

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("Accepted beat did not produce a result on time.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("Result strobe without a matching accepted beat.");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.last_out == $past(samples.last_in, LATENCY))
		else $error("Last flag does not match its beat.");

endmodule
